### hw/rtl/pstb_pkg.sv
// ----------------------------------------------------------------------------
// pstb_pkg: shared types and codes for the periodic soft timer bank
// Item layouts for the command and result channels, item kinds and
// result status codes.
// ----------------------------------------------------------------------------
package pstb_pkg;

	// item kinds
	localparam logic [1:0] KIND_TICK = 2'd0;
	localparam logic [1:0] KIND_REG  = 2'd1;
	localparam logic [1:0] KIND_REL  = 2'd2;
	localparam logic [1:0] KIND_ACK  = 2'd3;

	// result status codes
	localparam logic [1:0] STAT_OK     = 2'd0;
	localparam logic [1:0] STAT_RANGE  = 2'd1;
	localparam logic [1:0] STAT_FULL   = 2'd2;
	localparam logic [1:0] STAT_UNUSED = 2'd3;

	// longest period in ticks
	localparam int MAX_TICKS = 255;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] period_ms;
		logic [2:0]  slot;
	} cmd_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [2:0]  slot_taken;
		logic [7:0]  pending_mask;
		logic [15:0] tick_count;
		logic [20:0] elapsed_ms;
	} rsp_item_t;

endpackage

### hw/rtl/pstb_div.sv
// ----------------------------------------------------------------------------
// pstb_div: period to tick count divider
// Divides the period by the constant TICK_MS through a reciprocal multiply;
// the quotient is registered in the cycle after start. Valid for dividends
// below 256 * TICK_MS, where the quotient fits in eight bits.
// ----------------------------------------------------------------------------
module pstb_div #(
	parameter int TICK_MS = 30
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] dividend,
	output logic        done,
	output logic [7:0]  quotient
);
	// scale the reciprocal so the quotient is exact for every 16-bit dividend
	localparam int SHIFT = 16 + $clog2(TICK_MS);
	localparam longint unsigned RECIP_L =
		((64'd1 << SHIFT) + 64'(TICK_MS) - 64'd1) / 64'(TICK_MS);
	localparam logic [16:0] RECIP = 17'(RECIP_L);

	logic [32:0] prod;
	logic [7:0]  quo_next;
	logic [7:0]  quo_q;
	logic        done_q;

	// 16 by 17 bit product, quotient in the bits above the shift
	assign prod     = 33'(dividend) * 33'(RECIP);
	assign quo_next = 8'(prod >> SHIFT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= quo_next;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

### hw/rtl/periodic_soft_timer_bank.sv
// ----------------------------------------------------------------------------
// periodic_soft_timer_bank: bank of periodic software timer slots
// Ticks count down every used slot and flag expiries in a pending mask;
// register, release and acknowledge items manage the slots.
// ----------------------------------------------------------------------------
//
//  channel  | ports                    | handshake
//  ---------+--------------------------+--------------------------------------
//  command  | start, busy, cmd         | item taken at an edge with start & !busy
//  result   | done, rsp                | one item per strobe, one cycle, no stall
//
//  Per item: a tick takes one slot per cycle through the shared countdown
//  decrementer; a register item first scales the period by 1/TICK_MS in the
//  divider, then searches slot by slot; release and acknowledge go through
//  their own state; a failed range or slot index check is answered from idle.
//  Reset clears all slots, the pending mask and the tick count at once.
//  done marks rsp for one cycle, in which a new item may start; no stalls.
//
module periodic_soft_timer_bank #(
	parameter int SLOTS   = 6,
	parameter int TICK_MS = 30
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  pstb_pkg::cmd_item_t cmd,
	output logic                busy,
	output logic                done,
	output pstb_pkg::rsp_item_t rsp
);
	import pstb_pkg::*;

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);
	localparam logic [15:0] PER_MIN = 16'(TICK_MS);
	localparam logic [15:0] PER_MAX = 16'(MAX_TICKS * TICK_MS);
	localparam logic [20:0] MS_STEP = 21'(TICK_MS);

	// sequencer states
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_TICK = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_SRCH = 3'd3;
	localparam logic [2:0] ST_REL  = 3'd4;
	localparam logic [2:0] ST_ACK  = 3'd5;

	logic [2:0]       state_q, state_d;
	logic [IW-1:0]    idx_q, idx_d;
	logic [15:0]      tick_q, tick_d;
	logic [20:0]      elapsed_q, elapsed_d;
	logic [SLOTS-1:0] pend_q, pend_d;
	logic [7:0]       cyc_q, cyc_d;
	logic [7:0]       period_q [SLOTS];
	logic [7:0]       cd_q [SLOTS];
	logic             done_q;
	rsp_item_t        res_q, res_d;

	logic             wr_en;
	logic [7:0]       wr_per;
	logic [7:0]       wr_cd;
	logic             emit;
	logic [1:0]       stat;
	logic [2:0]       taken;
	logic [7:0]       rd_per;
	logic [7:0]       rd_cd;
	logic [7:0]       cd_dec;
	logic             slot_ok;
	logic             div_start;
	logic             div_done;
	logic [7:0]       div_quot;
	logic [SLOTS-1:0] used;

	pstb_div #(
		.TICK_MS(TICK_MS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (cmd.period_ms),
		.done     (div_done),
		.quotient (div_quot)
	);

	// read port of the slot table: always at the sequencer index
	assign rd_per  = period_q[idx_q];
	assign rd_cd   = cd_q[idx_q];
	assign cd_dec  = rd_cd - 8'd1;
	assign slot_ok = ({1'b0, cmd.slot} < 4'(SLOTS));

	always_comb begin
		state_d   = state_q;
		idx_d     = idx_q;
		tick_d    = tick_q;
		elapsed_d = elapsed_q;
		pend_d    = pend_q;
		cyc_d     = cyc_q;
		wr_en     = 1'b0;
		wr_per    = rd_per;
		wr_cd     = rd_cd;
		emit      = 1'b0;
		stat      = STAT_OK;
		taken     = '0;
		div_start = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					unique case (cmd.kind) inside
						KIND_TICK: begin
							// advance the tick count; elapsed time follows it
							tick_d    = tick_q + 16'd1;
							elapsed_d = (tick_d == 16'd0) ? '0 : elapsed_q + MS_STEP;
							idx_d     = '0;
							state_d   = ST_TICK;
						end
						KIND_REG: begin
							if (cmd.period_ms < PER_MIN || cmd.period_ms > PER_MAX) begin
								emit = 1'b1;
								stat = STAT_RANGE;
							end else begin
								div_start = 1'b1;
								state_d   = ST_DIV;
							end
						end
						KIND_REL, KIND_ACK: begin
							if (slot_ok) begin
								idx_d   = IW'(cmd.slot);
								state_d = (cmd.kind == KIND_REL) ? ST_REL : ST_ACK;
							end else begin
								emit = 1'b1;
								stat = STAT_UNUSED;
							end
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_TICK: begin
				// one slot per cycle: decrement, flag and reload on zero
				if (rd_per != 8'd0) begin
					wr_en = 1'b1;
					if (cd_dec == 8'd0) begin
						pend_d[idx_q] = 1'b1;
						wr_cd         = rd_per;
					end else begin
						wr_cd = cd_dec;
					end
				end
				if (idx_q == LAST_IDX) begin
					emit    = 1'b1;
					state_d = ST_IDLE;
				end else begin
					idx_d = idx_q + IW'(1);
				end
			end
			ST_DIV: begin
				// hold until the divider hands back the period in ticks
				if (div_done) begin
					cyc_d   = div_quot;
					idx_d   = '0;
					state_d = ST_SRCH;
				end
			end
			ST_SRCH: begin
				// claim the lowest free slot
				if (rd_per == 8'd0) begin
					wr_en   = 1'b1;
					wr_per  = cyc_q;
					wr_cd   = cyc_q;
					emit    = 1'b1;
					taken   = 3'(idx_q);
					state_d = ST_IDLE;
				end else if (idx_q == LAST_IDX) begin
					emit    = 1'b1;
					stat    = STAT_FULL;
					state_d = ST_IDLE;
				end else begin
					idx_d = idx_q + IW'(1);
				end
			end
			ST_REL: begin
				emit    = 1'b1;
				state_d = ST_IDLE;
				if (rd_per == 8'd0) begin
					stat = STAT_UNUSED;
				end else begin
					wr_en         = 1'b1;
					wr_per        = '0;
					wr_cd         = '0;
					pend_d[idx_q] = 1'b0;
				end
			end
			ST_ACK: begin
				emit    = 1'b1;
				state_d = ST_IDLE;
				if (rd_per == 8'd0) begin
					stat = STAT_UNUSED;
				end else begin
					pend_d[idx_q] = 1'b0;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// result shows the state after the item
		res_d.status       = stat;
		res_d.slot_taken   = taken;
		res_d.pending_mask = 8'(pend_d);
		res_d.tick_count   = tick_d;
		res_d.elapsed_ms   = elapsed_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			idx_q     <= '0;
			tick_q    <= '0;
			elapsed_q <= '0;
			pend_q    <= '0;
			done_q    <= 1'b0;
			for (int i = 0; i < SLOTS; i++) begin
				period_q[i] <= '0;
				cd_q[i]     <= '0;
			end
		end else begin
			state_q   <= state_d;
			idx_q     <= idx_d;
			tick_q    <= tick_d;
			elapsed_q <= elapsed_d;
			pend_q    <= pend_d;
			done_q    <= emit;
			if (wr_en) begin
				period_q[idx_q] <= wr_per;
				cd_q[idx_q]     <= wr_cd;
			end
		end
	end

	// payload registers: no reset needed
	always_ff @(posedge clk) begin
		cyc_q <= cyc_d;
		if (emit) begin
			res_q <= res_d;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign rsp  = res_q;

	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			used[i] = (period_q[i] != 8'd0);
		end
	end

`ifndef NO_ASSERTIONS
	// every result is issued with the sequencer back in idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while the sequencer is busy");

	// a taken item either answers at once or keeps the block busy
	a_start_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted item neither answered nor in progress");

	// a pending bit belongs only to a slot in use
	a_pend_used: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q & ~used) == '0)
		else $error("pending bit on a free slot");

	// a slot number is reported only by a successful register item
	a_taken_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.status == STAT_OK || rsp.slot_taken == 3'd0))
		else $error("slot reported on a failed item");
`endif

endmodule

### tb/sv/periodic_soft_timer_bank_tb.sv
// ----------------------------------------------------------------------------
// periodic_soft_timer_bank_tb: self-checking bench for the soft timer bank
// Starts with a short table of directed items, then sends random slot traffic
// in phases with varying sender gaps. Every result is checked field by field
// against its written-out table entry or the predictor.
// ----------------------------------------------------------------------------
module periodic_soft_timer_bank_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pstb_pkg::*;

	localparam int SLOTS   = 6;
	localparam int TICK_MS = 30;
	// cycles to wait after the last result so a stray strobe is still caught
	localparam int DRAIN_CYCLES = SLOTS + 12;
	localparam int MAX_REPORTS  = 10;

	// one row of the directed table; rows with known_rsp set carry their
	// expected result, all other rows take it from the predictor
	typedef struct {
		cmd_item_t c;
		bit        known_rsp;
		rsp_item_t r;
	} directed_row_t;

	logic      clk    = 1'b0;
	logic      arst_n = 1'b0;
	logic      start  = 1'b0;
	cmd_item_t cmd    = '0;
	logic      busy;
	logic      done;
	rsp_item_t rsp;

	// predictor copy of the bank
	logic [7:0]  bank_period[SLOTS];
	logic [7:0]  bank_countdown[SLOTS];
	logic [7:0]  bank_pending;
	logic [15:0] bank_ticks;

	rsp_item_t     timer_result_q[$];
	directed_row_t directed_rows[$];

	int idle_pct        = 0;
	int items_sent      = 0;
	int results_checked = 0;
	int mismatches      = 0;
	int status_seen[4]  = '{0, 0, 0, 0};

	periodic_soft_timer_bank #(
		.SLOTS   (SLOTS),
		.TICK_MS (TICK_MS)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done),
		.rsp    (rsp)
	);

	always #5 clk = ~clk;

	// Apply one item to the predictor state and return the result it causes.
	task automatic advance_timer_bank(input cmd_item_t c, output rsp_item_t r);
		logic [7:0] period_ticks;
		bit         claimed;
		r         = '0;
		r.status  = STAT_OK;
		claimed   = 1'b0;
		case (c.kind)
		KIND_TICK: begin
			bank_ticks = bank_ticks + 16'd1;
			// every used slot counts down; on zero flag it and reload
			for (int i = 0; i < SLOTS; i++) begin
				if (bank_period[i] != 8'd0) begin
					bank_countdown[i] = bank_countdown[i] - 8'd1;
					if (bank_countdown[i] == 8'd0) begin
						bank_pending[i]   = 1'b1;
						bank_countdown[i] = bank_period[i];
					end
				end
			end
		end
		KIND_REG: begin
			if (c.period_ms < TICK_MS || c.period_ms > MAX_TICKS * TICK_MS) begin
				r.status = STAT_RANGE;
			end else begin
				// truncate the period to whole ticks, take the lowest free slot
				period_ticks = 8'(c.period_ms / TICK_MS);
				r.status     = STAT_FULL;
				for (int i = 0; i < SLOTS; i++) begin
					if (!claimed && bank_period[i] == 8'd0) begin
						bank_period[i]    = period_ticks;
						bank_countdown[i] = period_ticks;
						r.status          = STAT_OK;
						r.slot_taken      = 3'(i);
						claimed           = 1'b1;
					end
				end
			end
		end
		default: begin
			// release and acknowledge both need a used slot in range
			if (c.slot >= SLOTS || bank_period[c.slot] == 8'd0) begin
				r.status = STAT_UNUSED;
			end else begin
				bank_pending[c.slot] = 1'b0;
				if (c.kind == KIND_REL) begin
					bank_period[c.slot]    = 8'd0;
					bank_countdown[c.slot] = 8'd0;
				end
			end
		end
		endcase
		r.pending_mask = bank_pending;
		r.tick_count   = bank_ticks;
		r.elapsed_ms   = 21'(32'(bank_ticks) * TICK_MS);
	endtask

	// Hold the item on the port until the block takes it, then record what it
	// should produce. Gaps go in front of the item, never between raise and take.
	task automatic send_timer_item(input cmd_item_t c, input bit known_rsp,
			input rsp_item_t known_r);
		rsp_item_t predicted;
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			cmd   <= cmd_item_t'(21'($urandom));
			@(posedge clk);
		end
		start <= 1'b1;
		cmd   <= c;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		advance_timer_bank(c, predicted);
		timer_result_q.push_back(known_rsp ? known_r : predicted);
		items_sent++;
	endtask

	task automatic add_row(input logic [1:0] kind, input logic [15:0] period_ms,
			input logic [2:0] slot, input bit known_rsp, input logic [1:0] status,
			input logic [2:0] taken, input logic [7:0] pend, input logic [15:0] ticks,
			input logic [20:0] elapsed);
		directed_row_t row;
		row.c         = '{kind: kind, period_ms: period_ms, slot: slot};
		row.known_rsp = known_rsp;
		row.r         = '{status: status, slot_taken: taken, pending_mask: pend,
			tick_count: ticks, elapsed_ms: elapsed};
		directed_rows.push_back(row);
	endtask

	function automatic void check_field(input string name, input int unsigned expv,
			input int unsigned actv);
		if (expv != actv) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("mismatch at result %0d: %s expected %0d, got %0d",
					results_checked, name, expv, actv);
		end
	endfunction

	// Take every result strobe and compare it with the oldest expectation.
	always @(posedge clk) begin
		rsp_item_t want;
		if (arst_n && done) begin
			if (timer_result_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("result with nothing expected: status %0d tick %0d",
						rsp.status, rsp.tick_count);
			end else begin
				want = timer_result_q.pop_front();
				check_field("status", want.status, rsp.status);
				check_field("slot_taken", want.slot_taken, rsp.slot_taken);
				check_field("pending_mask", want.pending_mask, rsp.pending_mask);
				check_field("tick_count", want.tick_count, rsp.tick_count);
				check_field("elapsed_ms", want.elapsed_ms, rsp.elapsed_ms);
				status_seen[want.status]++;
				results_checked++;
			end
		end
	end

	// Stop a hung run; a correct run finishes in well under a tenth of this.
	initial begin
		#30_000_000;
		$display("timeout with %0d results still expected", timer_result_q.size());
		$display("periodic_soft_timer_bank_tb: done, errors");
		$finish;
	end

	initial begin : stimulus
		int        used[$];
		int        roll;
		cmd_item_t c;
		rsp_item_t none;

		none = '0;
		for (int i = 0; i < SLOTS; i++) begin
			bank_period[i]    = '0;
			bank_countdown[i] = '0;
		end
		bank_pending = '0;
		bank_ticks   = '0;

		// Hold reset, then release it on an edge.
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table. Early rows run from the reset state, so their results
		// can be written out; the tick that opens it leaves the count at one.
		add_row(KIND_TICK, 16'd0,    3'd0, 1'b1, STAT_OK,     3'd0, 8'h00, 16'd1, 21'd30);
		add_row(KIND_ACK,  16'hFFFF, 3'd0, 1'b1, STAT_UNUSED, 3'd0, 8'h00, 16'd1, 21'd30);
		add_row(KIND_REL,  16'd0,    3'd7, 1'b1, STAT_UNUSED, 3'd0, 8'h00, 16'd1, 21'd30);
		add_row(KIND_REG,  16'd0,    3'd0, 1'b1, STAT_RANGE,  3'd0, 8'h00, 16'd1, 21'd30);
		add_row(KIND_REG,  16'd29,   3'd7, 1'b1, STAT_RANGE,  3'd0, 8'h00, 16'd1, 21'd30);
		add_row(KIND_REG,  16'd7651, 3'd0, 1'b1, STAT_RANGE,  3'd0, 8'h00, 16'd1, 21'd30);
		add_row(KIND_REG,  16'hFFFF, 3'd7, 1'b1, STAT_RANGE,  3'd0, 8'h00, 16'd1, 21'd30);
		// fill the bank: shortest period, longest, and truncated ones
		add_row(KIND_REG,  16'd30,   3'd0, 1'b1, STAT_OK,     3'd0, 8'h00, 16'd1, 21'd30);
		add_row(KIND_REG,  16'd7650, 3'd0, 1'b1, STAT_OK,     3'd1, 8'h00, 16'd1, 21'd30);
		add_row(KIND_REG,  16'd59,   3'd0, 1'b1, STAT_OK,     3'd2, 8'h00, 16'd1, 21'd30);
		add_row(KIND_REG,  16'd61,   3'd0, 1'b1, STAT_OK,     3'd3, 8'h00, 16'd1, 21'd30);
		add_row(KIND_REG,  16'd90,   3'd0, 1'b1, STAT_OK,     3'd4, 8'h00, 16'd1, 21'd30);
		add_row(KIND_REG,  16'd45,   3'd0, 1'b1, STAT_OK,     3'd5, 8'h00, 16'd1, 21'd30);
		add_row(KIND_REG,  16'd30,   3'd0, 1'b1, STAT_FULL,   3'd0, 8'h00, 16'd1, 21'd30);
		// expiries, acknowledges with and without pending, out-of-range slots
		add_row(KIND_TICK, 16'd0,    3'd0, 1'b0, '0, '0, '0, '0, '0);
		add_row(KIND_TICK, 16'd0,    3'd0, 1'b0, '0, '0, '0, '0, '0);
		add_row(KIND_ACK,  16'd0,    3'd0, 1'b0, '0, '0, '0, '0, '0);
		add_row(KIND_ACK,  16'd0,    3'd6, 1'b0, '0, '0, '0, '0, '0);
		add_row(KIND_ACK,  16'd0,    3'd7, 1'b0, '0, '0, '0, '0, '0);
		add_row(KIND_REL,  16'd0,    3'd1, 1'b0, '0, '0, '0, '0, '0);
		add_row(KIND_REG,  16'd255,  3'd0, 1'b0, '0, '0, '0, '0, '0);
		add_row(KIND_ACK,  16'd0,    3'd4, 1'b0, '0, '0, '0, '0, '0);
		add_row(KIND_REL,  16'd0,    3'd3, 1'b0, '0, '0, '0, '0, '0);
		add_row(KIND_ACK,  16'd0,    3'd3, 1'b0, '0, '0, '0, '0, '0);
		add_row(KIND_TICK, 16'd0,    3'd0, 1'b0, '0, '0, '0, '0, '0);
		add_row(KIND_REL,  16'd0,    3'd0, 1'b0, '0, '0, '0, '0, '0);

		foreach (directed_rows[i])
			send_timer_item(directed_rows[i].c, directed_rows[i].known_rsp,
				directed_rows[i].r);

		// Random traffic in three phases: back to back, half the cycles idle,
		// and a light sprinkle of gaps. Mostly well-formed slot use with short
		// periods so slots expire often; some full-range periods and slots.
		for (int phase = 0; phase < 3; phase++) begin
			idle_pct = (phase == 0) ? 0 : (phase == 1) ? 50 : 6;
			for (int n = 0; n < 308; n++) begin
				used.delete();
				for (int i = 0; i < SLOTS; i++)
					if (bank_period[i] != 8'd0)
						used.push_back(i);
				c      = cmd_item_t'(21'($urandom));
				roll   = $urandom_range(0, 99);
				c.kind = (roll < 45) ? KIND_TICK : (roll < 65) ? KIND_REG :
					(roll < 80) ? KIND_REL : KIND_ACK;
				if (c.kind == KIND_REG) begin
					roll = $urandom_range(0, 9);
					if (roll < 6)
						c.period_ms = 16'($urandom_range(TICK_MS, 10 * TICK_MS));
					else if (roll < 8)
						c.period_ms = 16'($urandom_range(TICK_MS, MAX_TICKS * TICK_MS));
				end else if (c.kind != KIND_TICK && used.size() != 0 &&
						$urandom_range(0, 9) < 8) begin
					c.slot = 3'(used[$urandom_range(0, used.size() - 1)]);
				end
				send_timer_item(c, 1'b0, none);
			end
		end

		// Drop start, drain the outstanding results, then watch for strays.
		start <= 1'b0;
		while (timer_result_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d items, checked %0d results, final tick count %0d",
			items_sent, results_checked, bank_ticks);
		$display("status seen: ok %0d, range %0d, full %0d, unused %0d; mismatches %0d",
			status_seen[STAT_OK], status_seen[STAT_RANGE], status_seen[STAT_FULL],
			status_seen[STAT_UNUSED], mismatches);
		if (mismatches == 0 && timer_result_q.size() == 0)
			$display("periodic_soft_timer_bank_tb: done, clean");
		else
			$display("periodic_soft_timer_bank_tb: done, errors");
		$finish;
	end

endmodule

### filelist.f
hw/rtl/pstb_pkg.sv
hw/rtl/pstb_div.sv
hw/rtl/periodic_soft_timer_bank.sv
tb/sv/periodic_soft_timer_bank_tb.sv
